// ===== hdl/box_overlap_ratio_test_defines.svh =====
// assertion macros for the box overlap ratio test block
// used by the top level only, no other dependencies
`ifndef BOX_OVERLAP_RATIO_TEST_DEFINES_SVH
`define BOX_OVERLAP_RATIO_TEST_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BOR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define BOR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/box_ovr_pkg.sv =====
// shared widths, register indexes and structs of the box overlap ratio test
// no dependencies
package box_ovr_pkg;

  localparam int COORD_BITS     = 16;
  localparam int SIZE_BITS      = COORD_BITS - 1;
  localparam int EDGE_BITS      = COORD_BITS + 2;
  localparam int FRAC_BITS      = 16;
  localparam int SCORE_BITS     = FRAC_BITS + 1;
  localparam int AREA_BITS      = 2 * SIZE_BITS;
  localparam int UNION_BITS     = AREA_BITS + 1;
  localparam int PROD_BITS      = UNION_BITS + SCORE_BITS;
  localparam int DIV_STAGES     = FRAC_BITS + 1;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = (SCORE_BITS > COORD_BITS) ? SCORE_BITS : COORD_BITS;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_REF_X      = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_REF_Y      = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_REF_WIDTH  = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_REF_HEIGHT = CFG_INDEX_BITS'(3);
  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD  = CFG_INDEX_BITS'(4);
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNION_MODE = CFG_INDEX_BITS'(5);
  localparam logic [CFG_INDEX_BITS-1:0] REG_BY_REF     = CFG_INDEX_BITS'(6);

  // 1.0 in score format, threshold reset is 0.5
  localparam logic [SCORE_BITS-1:0] SCORE_ONE    = SCORE_BITS'(1) << FRAC_BITS;
  localparam logic [SCORE_BITS-1:0] THRESH_RESET = SCORE_BITS'(1) << (FRAC_BITS - 1);

  // configuration seen by the datapath
  typedef struct packed {
    logic [COORD_BITS-1:0] ref_x;
    logic [COORD_BITS-1:0] ref_y;
    logic [SIZE_BITS-1:0]  ref_width;
    logic [SIZE_BITS-1:0]  ref_height;
    logic [SCORE_BITS-1:0] overlap_threshold;
    logic                  union_mode;
    logic                  by_reference;
  } cfg_t;

  // geometry result handed to the divider
  typedef struct packed {
    logic                  hit;
    logic [AREA_BITS-1:0]  num;
    logic [UNION_BITS-1:0] den;
  } geom_t;

endpackage

// ===== hdl/box_overlap_ratio_test.sv =====
// top level of the box overlap ratio test: configuration registers and pipeline
// depends on box_ovr_pkg, box_ovr_geom, box_ovr_div, box_overlap_ratio_test_defines.svh
//
//  channel  handshake              payload
//  -------  ---------------------  ----------------------------------------
//  cfg      cfg_we                 cfg_index, cfg_data
//  input    in_valid / in_stall    box_x, box_y, box_width, box_height
//  output   out_valid / out_stall  hit, overlap_score
//
// one box per cycle sustained while out_stall is low: 6 geometry stages (edges,
// extents, area multipliers, union, threshold product, threshold compare)
// followed by a 17 stage divider that retires one quotient bit per stage.
// reset clears the valid bits and loads the register defaults.
// a stage holds only while it is full and the stage after it holds, so empty
// slots fill up under output stall and in_stall rises only when all are full.
`include "box_overlap_ratio_test_defines.svh"

module box_overlap_ratio_test
  import box_ovr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [COORD_BITS-1:0]     box_x,
  input  logic [COORD_BITS-1:0]     box_y,
  input  logic [SIZE_BITS-1:0]      box_width,
  input  logic [SIZE_BITS-1:0]      box_height,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      hit,
  output logic [SCORE_BITS-1:0]     overlap_score
);

  cfg_t  cfg;
  geom_t geom_data;
  logic  geom_in_ready;
  logic  geom_valid;
  logic  div_in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_x             <= '0;
      cfg.ref_y             <= '0;
      cfg.ref_width         <= '0;
      cfg.ref_height        <= '0;
      cfg.overlap_threshold <= THRESH_RESET;
      cfg.union_mode        <= 1'b1;
      cfg.by_reference      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REF_X:      cfg.ref_x             <= cfg_data[COORD_BITS-1:0];
        REG_REF_Y:      cfg.ref_y             <= cfg_data[COORD_BITS-1:0];
        REG_REF_WIDTH:  cfg.ref_width         <= cfg_data[SIZE_BITS-1:0];
        REG_REF_HEIGHT: cfg.ref_height        <= cfg_data[SIZE_BITS-1:0];
        REG_THRESHOLD:  cfg.overlap_threshold <= cfg_data[SCORE_BITS-1:0];
        REG_UNION_MODE: cfg.union_mode        <= cfg_data[0];
        REG_BY_REF:     cfg.by_reference      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // geometry and threshold test
  box_ovr_geom u_geom (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (geom_in_ready),
    .box_x      (box_x),
    .box_y      (box_y),
    .box_width  (box_width),
    .box_height (box_height),
    .out_valid  (geom_valid),
    .out_ready  (div_in_ready),
    .out_data   (geom_data)
  );

  // score quotient
  box_ovr_div u_div (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (geom_valid),
    .in_ready      (div_in_ready),
    .in_data       (geom_data),
    .out_valid     (out_valid),
    .out_ready     (!out_stall),
    .hit           (hit),
    .overlap_score (overlap_score)
  );

  assign in_stall = !geom_in_ready;

  // input backpressure only comes from a stalled result
  `BOR_ASSERT_IMPL(a_stall_source, clk, rst, in_stall, out_valid && out_stall, "stray stall")
  // a full pipeline stays full while the result is not taken
  `BOR_ASSERT_NEXT(a_full_holds, clk, rst, in_stall, in_stall || !out_stall, "full pipe moved")
  // ratio never exceeds one
  `BOR_ASSERT_IMPL(a_score_range, clk, rst, out_valid, overlap_score <= SCORE_ONE, "bad score")

endmodule

// ===== hdl/box_ovr_geom.sv =====
// geometry front end: edges, overlap, areas, divisor select and threshold test
// depends on box_ovr_pkg
module box_ovr_geom
  import box_ovr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] box_x,
  input  logic [COORD_BITS-1:0] box_y,
  input  logic [SIZE_BITS-1:0]  box_width,
  input  logic [SIZE_BITS-1:0]  box_height,
  output logic                  out_valid,
  input  logic                  out_ready,
  output geom_t                 out_data
);

  // valid bits and per-stage load enables, stage 6 is the output register
  logic v1, v2, v3, v4, v5, v6;
  logic r1, r2, r3, r4, r5, r6;

  assign r6 = !v6 || out_ready;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready  = r1;
  assign out_valid = v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
    end
  end

  // stage 1: left, right, top and bottom of the intersection
  logic signed [EDGE_BITS-1:0] bx_l, bx_r, rx_l, rx_r;
  logic signed [EDGE_BITS-1:0] by_t, by_b, ry_t, ry_b;
  logic signed [EDGE_BITS-1:0] s1_left, s1_right, s1_top, s1_bottom;
  logic [SIZE_BITS-1:0]        s1_bw, s1_bh;

  assign bx_l = EDGE_BITS'($signed(box_x));
  assign rx_l = EDGE_BITS'($signed(cfg.ref_x));
  assign by_t = EDGE_BITS'($signed(box_y));
  assign ry_t = EDGE_BITS'($signed(cfg.ref_y));
  assign bx_r = bx_l + $signed(EDGE_BITS'(box_width)) - EDGE_BITS'(1);
  assign rx_r = rx_l + $signed(EDGE_BITS'(cfg.ref_width)) - EDGE_BITS'(1);
  assign by_b = by_t + $signed(EDGE_BITS'(box_height)) - EDGE_BITS'(1);
  assign ry_b = ry_t + $signed(EDGE_BITS'(cfg.ref_height)) - EDGE_BITS'(1);

  always_ff @(posedge clk) begin
    if (r1) begin
      s1_left   <= (bx_l > rx_l) ? bx_l : rx_l;
      s1_right  <= (bx_r < rx_r) ? bx_r : rx_r;
      s1_top    <= (by_t > ry_t) ? by_t : ry_t;
      s1_bottom <= (by_b < ry_b) ? by_b : ry_b;
      s1_bw     <= box_width;
      s1_bh     <= box_height;
    end
  end

  // stage 2: overlap extent and the overlap flag
  logic signed [EDGE_BITS-1:0] dx, dy, dx_p1, dy_p1;
  logic [SIZE_BITS-1:0]        s2_wx, s2_wy, s2_bw, s2_bh;
  logic                        s2_ovl;

  assign dx    = s1_right - s1_left;
  assign dy    = s1_bottom - s1_top;
  assign dx_p1 = dx + EDGE_BITS'(1);
  assign dy_p1 = dy + EDGE_BITS'(1);

  always_ff @(posedge clk) begin
    if (r2) begin
      s2_wx  <= dx_p1[SIZE_BITS-1:0];
      s2_wy  <= dy_p1[SIZE_BITS-1:0];
      s2_ovl <= !dx[EDGE_BITS-1] && !dy[EDGE_BITS-1];
      s2_bw  <= s1_bw;
      s2_bh  <= s1_bh;
    end
  end

  // stage 3: intersection, candidate and reference areas
  logic [AREA_BITS-1:0] s3_inter, s3_cand, s3_refa;
  logic                 s3_ovl;

  always_ff @(posedge clk) begin
    if (r3) begin
      s3_inter <= AREA_BITS'(s2_wx) * AREA_BITS'(s2_wy);
      s3_cand  <= AREA_BITS'(s2_bw) * AREA_BITS'(s2_bh);
      s3_refa  <= AREA_BITS'(cfg.ref_width) * AREA_BITS'(cfg.ref_height);
      s3_ovl   <= s2_ovl;
    end
  end

  // stage 4: union area, divisor and area for the threshold test
  logic [UNION_BITS-1:0] uni;
  logic [UNION_BITS-1:0] s4_den, s4_harea;
  logic [AREA_BITS-1:0]  s4_num;
  logic                  s4_ovl;

  assign uni = UNION_BITS'(s3_refa) + UNION_BITS'(s3_cand) - UNION_BITS'(s3_inter);

  always_ff @(posedge clk) begin
    if (r4) begin
      s4_num <= s3_inter;
      s4_ovl <= s3_ovl;
      if (cfg.union_mode) begin
        s4_den   <= uni;
        s4_harea <= uni;
      end else begin
        s4_den   <= cfg.by_reference ? UNION_BITS'(s3_refa) : UNION_BITS'(s3_cand);
        s4_harea <= UNION_BITS'(s3_cand);
      end
    end
  end

  // stage 5: area times threshold
  logic [PROD_BITS-1:0]  s5_prod;
  logic [AREA_BITS-1:0]  s5_num;
  logic [UNION_BITS-1:0] s5_den;
  logic                  s5_ovl;

  always_ff @(posedge clk) begin
    if (r5) begin
      s5_prod <= PROD_BITS'(s4_harea) * PROD_BITS'(cfg.overlap_threshold);
      s5_num  <= s4_num;
      s5_den  <= s4_den;
      s5_ovl  <= s4_ovl;
    end
  end

  // stage 6: exact threshold compare, no overlap becomes 0 over 1
  logic [PROD_BITS-1:0] lhs;

  assign lhs = PROD_BITS'({s5_num, {FRAC_BITS{1'b0}}});

  always_ff @(posedge clk) begin
    if (r6) begin
      out_data.hit <= s5_ovl && (lhs >= s5_prod);
      out_data.num <= s5_ovl ? s5_num : '0;
      out_data.den <= s5_ovl ? s5_den : UNION_BITS'(1);
    end
  end

endmodule

// ===== hdl/box_ovr_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// depends on box_ovr_pkg
module box_ovr_div
  import box_ovr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  geom_t                 in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [SCORE_BITS-1:0] overlap_score
);

  localparam int SHIFT_BITS = UNION_BITS + 1;

  logic [DIV_STAGES-1:0] vld;
  logic [DIV_STAGES:0]   rdy;
  logic [DIV_STAGES-1:0] hit_q;
  logic [UNION_BITS-1:0] rem   [DIV_STAGES];
  logic [UNION_BITS-1:0] den_q [DIV_STAGES];
  logic [SCORE_BITS-1:0] quo   [DIV_STAGES];

  assign rdy[DIV_STAGES] = out_ready;
  assign in_ready        = rdy[0];
  assign out_valid       = vld[DIV_STAGES-1];
  assign hit             = hit_q[DIV_STAGES-1];
  assign overlap_score   = quo[DIV_STAGES-1];

  // integer bit of the quotient
  logic [UNION_BITS-1:0] num_ext;
  logic                  ge0;

  assign num_ext = UNION_BITS'(in_data.num);
  assign ge0     = num_ext >= in_data.den;
  assign rdy[0]  = !vld[0] || rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rem[0]   <= ge0 ? (num_ext - in_data.den) : num_ext;
      quo[0]   <= SCORE_BITS'(ge0);
      den_q[0] <= in_data.den;
      hit_q[0] <= in_data.hit;
    end
  end

  // fraction bits, one compare and subtract per stage
  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_step
    logic [SHIFT_BITS-1:0] shifted;
    logic [SHIFT_BITS-1:0] diff;
    logic                  ge;

    assign shifted = {rem[k-1], 1'b0};
    assign diff    = shifted - SHIFT_BITS'(den_q[k-1]);
    assign ge      = shifted >= SHIFT_BITS'(den_q[k-1]);
    assign rdy[k]  = !vld[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rem[k]   <= ge ? diff[UNION_BITS-1:0] : shifted[UNION_BITS-1:0];
        quo[k]   <= {quo[k-1][SCORE_BITS-2:0], ge};
        den_q[k] <= den_q[k-1];
        hit_q[k] <= hit_q[k-1];
      end
    end
  end

endmodule
